### sv/pwmwd_pkg.sv
`timescale 1ns / 1ps

package pwmwd_pkg;

  localparam int DUTY_W        = 12;
  localparam int PERIOD_W      = 16;
  localparam int TIMEOUT_W     = 32;
  localparam int PROD_W        = DUTY_W + PERIOD_W;
  localparam int CFG_DATA_W    = 32;

  localparam int DUTY_FULL_SCALE_DEF = 1000;

  localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 16'd2000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000000;

  typedef enum logic {
    CFG_PERIOD  = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_index_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ontime_stat_t;

endpackage

### sv/pwm_generator_with_command_watchdog_core.sv
`timescale 1ns / 1ps
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one tick word per cycle unless the output stalls; after a duty write or a
// period write the input stalls while the on-time multiply and reciprocal pipeline runs.
// Reset is synchronous and active low: period 2000, timeout 1000000, all PWM
// and watchdog state cleared, output channel empty.

module pwm_generator_with_command_watchdog_core #(
  parameter int DUTY_FULL_SCALE = pwmwd_pkg::DUTY_FULL_SCALE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,   // duty_value
  input  logic                             in_tuser,   // command
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // pin_level, timed_out, duty_active
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [pwmwd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DUTY_W    = pwmwd_pkg::DUTY_W;
  localparam int PERIOD_W  = pwmwd_pkg::PERIOD_W;
  localparam int TIMEOUT_W = pwmwd_pkg::TIMEOUT_W;
  localparam logic [DUTY_W-1:0] FS = DUTY_W'(DUTY_FULL_SCALE);

  logic [PERIOD_W-1:0]  period_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [DUTY_W-1:0]    duty_r, duty_nxt;
  logic [PERIOD_W-1:0]  on_r, on_nxt;
  logic [PERIOD_W-1:0]  cnt_r, cnt_nxt;
  logic                 ph_r, ph_nxt;
  logic [TIMEOUT_W-1:0] tsw_r, tsw_nxt;
  logic                 wd_r, wd_nxt;
  logic                 out_tvalid_r;
  logic [7:0]           out_tdata_r;
  logic [2:0]           res;

  pwmwd_pkg::ontime_stat_t stat;
  logic [PERIOD_W-1:0]     unit_on_time;
  logic                    acc;
  logic                    cfg_period_wr;
  logic                    unit_start;
  logic [DUTY_W-1:0]       unit_duty;
  logic [DUTY_W-1:0]       in_duty;
  logic                    is_write;

  assign in_duty       = in_tdata[DUTY_W-1:0];
  assign is_write      = (in_tuser == pwmwd_pkg::CMD_WRITE);
  assign in_tready     = (!out_tvalid_r || out_tready) && !stat.busy;
  assign acc           = in_tvalid && in_tready;
  assign cfg_period_wr = cfg_we && (cfg_index == pwmwd_pkg::CFG_PERIOD);
  assign unit_start    = (acc && is_write) || cfg_period_wr;
  assign unit_duty     = cfg_period_wr ? duty_r : in_duty;

  pwmwd_ontime #(
    .DUTY_FULL_SCALE(DUTY_FULL_SCALE)
  ) u_ontime (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (unit_start),
    .duty    (unit_duty),
    .period  (cfg_period_wr ? cfg_data[PERIOD_W-1:0] : period_r),
    .stat    (stat),
    .on_time (unit_on_time)
  );

  always_comb begin
    logic [TIMEOUT_W-1:0] tsw_inc;
    logic                 trip;
    logic [DUTY_W-1:0]    duty_t;
    logic                 active;
    logic [PERIOD_W-1:0]  len_low;
    logic [PERIOD_W-1:0]  len_cur;
    logic [PERIOD_W-1:0]  len;
    logic                 ph1;
    logic [PERIOD_W-1:0]  cnt1;
    logic [PERIOD_W:0]    cnt2;
    logic                 level;

    duty_nxt = duty_r;
    on_nxt   = on_r;
    cnt_nxt  = cnt_r;
    ph_nxt   = ph_r;
    tsw_nxt  = tsw_r;
    wd_nxt   = wd_r;
    res      = 3'b000;

    tsw_inc = (tsw_r == {TIMEOUT_W{1'b1}}) ? tsw_r : tsw_r + TIMEOUT_W'(1);
    trip    = tsw_inc > timeout_r;
    len_low = (period_r > on_r) ? period_r - on_r : '0;
    duty_t  = '0;
    active  = 1'b0;
    len_cur = '0;
    len     = '0;
    ph1     = ph_r;
    cnt1    = cnt_r;
    cnt2    = '0;
    level   = 1'b0;

    if (is_write) begin
      duty_t = in_duty;
      active = (duty_t != '0) && (duty_t <= FS) && (period_r != '0);
      level  = active ? ph_r : 1'b0;
      if (acc) begin
        duty_nxt = in_duty;
        tsw_nxt  = '0;
        wd_nxt   = 1'b0;
      end
      res = {(duty_t != '0) && (duty_t <= FS), 1'b0, level};
    end else begin
      duty_t = trip ? '0 : duty_r;
      active = (duty_t != '0) && (duty_t <= FS) && (period_r != '0);
      if (active) begin
        len_cur = ph_r ? on_r : len_low;
        if (len_cur == '0) begin
          ph1  = !ph_r;
          cnt1 = '0;
        end
        len   = ph1 ? on_r : len_low;
        level = ph1;
        cnt2  = {1'b0, cnt1} + (PERIOD_W+1)'(1);
      end
      if (acc) begin
        tsw_nxt = tsw_inc;
        if (trip) begin
          duty_nxt = '0;
          on_nxt   = '0;
          wd_nxt   = 1'b1;
        end
        if (active) begin
          if (cnt2 >= {1'b0, len}) begin
            cnt_nxt = '0;
            ph_nxt  = !ph1;
          end else begin
            cnt_nxt = cnt2[PERIOD_W-1:0];
            ph_nxt  = ph1;
          end
        end else begin
          cnt_nxt = '0;
        end
      end
      res = {(duty_t != '0) && (duty_t <= FS), trip | wd_r, level};
    end

    if (stat.done) begin
      on_nxt = unit_on_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= pwmwd_pkg::PERIOD_RESET;
      timeout_r    <= pwmwd_pkg::TIMEOUT_RESET;
      duty_r       <= '0;
      on_r         <= '0;
      cnt_r        <= '0;
      ph_r         <= 1'b0;
      tsw_r        <= '0;
      wd_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      duty_r <= duty_nxt;
      on_r   <= on_nxt;
      cnt_r  <= cnt_nxt;
      ph_r   <= ph_nxt;
      tsw_r  <= tsw_nxt;
      wd_r   <= wd_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pwmwd_pkg::CFG_PERIOD:  period_r  <= cfg_data[PERIOD_W-1:0];
          pwmwd_pkg::CFG_TIMEOUT: timeout_r <= cfg_data[TIMEOUT_W-1:0];
          default:                period_r  <= period_r;
        endcase
      end
      if (acc) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
    if (acc) begin
      out_tdata_r <= {5'b00000, res};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### sv/pwmwd_ontime.sv
`timescale 1ns / 1ps

module pwmwd_ontime #(
  parameter int DUTY_FULL_SCALE = pwmwd_pkg::DUTY_FULL_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pwmwd_pkg::DUTY_W-1:0]   duty,
  input  logic [pwmwd_pkg::PERIOD_W-1:0] period,
  output pwmwd_pkg::ontime_stat_t        stat,
  output logic [pwmwd_pkg::PERIOD_W-1:0] on_time
);

  localparam int PROD_W  = pwmwd_pkg::PROD_W;
  localparam int HALF    = PROD_W / 2;
  localparam int RECIP_W = PROD_W + 1;
  localparam int PP_W    = (PROD_W - HALF) + RECIP_W;
  localparam int SUM_W   = PROD_W + RECIP_W;
  localparam int QD_W    = RECIP_W + pwmwd_pkg::DUTY_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << PROD_W) / DUTY_FULL_SCALE);
  localparam logic [QD_W-1:0]    DIVISOR = QD_W'(DUTY_FULL_SCALE);

  logic              v1_r, v2_r, v3_r;
  logic [PROD_W-1:0] prod1_r, prod2_r, prod3_r;
  logic [PP_W-1:0]   pphi_r, pplo_r;
  logic [RECIP_W-1:0] q0_r;

  logic [PROD_W-1:0]  prod_nxt;
  logic [PP_W-1:0]    pphi_nxt, pplo_nxt;
  logic [SUM_W-1:0]   sum;
  logic [QD_W-1:0]    qd, rem;
  logic [RECIP_W-1:0] q;

  assign prod_nxt = PROD_W'(duty) * PROD_W'(period);
  assign pphi_nxt = PP_W'(prod1_r[PROD_W-1:HALF]) * PP_W'(RECIP);
  assign pplo_nxt = PP_W'(prod1_r[HALF-1:0]) * PP_W'(RECIP);
  assign sum      = (SUM_W'(pphi_r) << HALF) + SUM_W'(pplo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    prod1_r <= prod_nxt;
    prod2_r <= prod1_r;
    prod3_r <= prod2_r;
    pphi_r  <= pphi_nxt;
    pplo_r  <= pplo_nxt;
    q0_r    <= sum[SUM_W-1:PROD_W];
  end

  // The reciprocal estimate is at most one below the true quotient.
  always_comb begin
    qd  = QD_W'(q0_r) * DIVISOR;
    rem = QD_W'(prod3_r) - qd;
    q   = (rem >= DIVISOR) ? q0_r + RECIP_W'(1) : q0_r;
    if (q > RECIP_W'({pwmwd_pkg::PERIOD_W{1'b1}})) begin
      on_time = {pwmwd_pkg::PERIOD_W{1'b1}};
    end else begin
      on_time = q[pwmwd_pkg::PERIOD_W-1:0];
    end
  end

  assign stat.busy = v1_r | v2_r | v3_r;
  assign stat.done = v3_r;

endmodule

### bench/tb_pwm_generator_with_command_watchdog_core.sv
`timescale 1ns / 1ps

module tb_pwm_generator_with_command_watchdog_core;
  import pwmwd_pkg::*;

  localparam int FULL_SCALE = DUTY_FULL_SCALE_DEF;
  localparam int RANDOM_WORDS = 1950;

  typedef struct {
    bit pin_level;
    bit timed_out;
    bit duty_active;
  } pwm_word_t;

  class pwm_level_tracker;
    int unsigned period;
    int unsigned timeout;
    int unsigned duty;
    int unsigned on_len;
    int unsigned phase_cnt;
    bit high_phase;
    int unsigned idle_ticks;
    bit tripped;
    pwm_word_t levels_due[$];
    int fail_count;

    function new();
      period = PERIOD_RESET;
      timeout = TIMEOUT_RESET;
      duty = 0;
      on_len = 0;
      phase_cnt = 0;
      high_phase = 0;
      idle_ticks = 0;
      tripped = 0;
      fail_count = 0;
    endfunction

    function int unsigned on_time_of(int unsigned d, int unsigned p);
      longint unsigned v;
      v = (longint'(d) * longint'(p)) / FULL_SCALE;
      return (v > 64'hFFFF) ? 32'hFFFF : int'(v);
    endfunction

    function bit duty_ok();
      return duty != 0 && duty <= FULL_SCALE;
    endfunction

    function int unsigned len_of(bit h);
      if (h) begin
        return on_len;
      end
      return (period > on_len) ? period - on_len : 0;
    endfunction

    function void set_register(cfg_index_t idx, logic [31:0] val);
      if (idx == CFG_PERIOD) begin
        period = val[15:0];
        on_len = on_time_of(duty, period);
      end else begin
        timeout = val;
      end
    endfunction

    function void note_word(cmd_t cmd, logic [11:0] d);
      pwm_word_t w;
      int unsigned len;
      bit lvl;
      lvl = 0;
      if (cmd == CMD_WRITE) begin
        duty = d;
        on_len = on_time_of(duty, period);
        idle_ticks = 0;
        tripped = 0;
        lvl = (duty_ok() && period != 0) ? high_phase : 1'b0;
      end else begin
        if (idle_ticks != 32'hFFFF_FFFF) begin
          idle_ticks++;
        end
        if (idle_ticks > timeout) begin
          duty = 0;
          on_len = 0;
          tripped = 1;
        end
        if (duty_ok() && period != 0) begin
          len = len_of(high_phase);
          if (len == 0) begin
            high_phase = ~high_phase;
            phase_cnt = 0;
            len = len_of(high_phase);
          end
          lvl = high_phase;
          phase_cnt++;
          if (phase_cnt >= len) begin
            phase_cnt = 0;
            high_phase = ~high_phase;
          end
        end else begin
          phase_cnt = 0;
        end
      end
      w.pin_level = lvl;
      w.timed_out = tripped;
      w.duty_active = duty_ok();
      levels_due.push_back(w);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
    endtask

    task check_word(logic [7:0] data);
      pwm_word_t w;
      if (levels_due.size() == 0) begin
        report($sformatf("result word 0x%02h with nothing pending", data));
      end else begin
        w = levels_due.pop_front();
        if (data[0] !== w.pin_level) begin
          report($sformatf("pin_level expected %0d got %b", w.pin_level, data[0]));
        end
        if (data[1] !== w.timed_out) begin
          report($sformatf("timed_out expected %0d got %b", w.timed_out, data[1]));
        end
        if (data[2] !== w.duty_active) begin
          report($sformatf("duty_active expected %0d got %b", w.duty_active, data[2]));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pwm_level_tracker tracker = new();
  bit idling_on = 1'b0;
  int words_sent = 0;
  int rx_hold = 0;

  pwm_generator_with_command_watchdog_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idling_on || r < 60) begin
      return 0;
    end
    if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function logic [11:0] pick_duty();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 12'd0;
    if (r < 22) return 12'(FULL_SCALE);
    if (r < 32) return 12'($urandom_range(1, 10));
    if (r < 55) return 12'($urandom_range(11, FULL_SCALE - 1));
    if (r < 70) return 12'($urandom_range(FULL_SCALE + 1, 4095));
    if (r < 75) return 12'(FULL_SCALE + 1);
    if (r < 80) return 12'hFFF;
    return 12'($urandom_range(0, 4095));
  endfunction

  function logic [31:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd1;
    if (r < 15) return 32'd65535;
    if (r < 45) return $urandom_range(2, 8);
    if (r < 80) return $urandom_range(9, 40);
    if (r < 95) return $urandom_range(41, 400);
    return $urandom_range(1, 65535);
  endfunction

  function logic [31:0] pick_timeout();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd1;
    if (r < 15) return 32'hFFFF_FFFF;
    if (r < 55) return $urandom_range(2, 40);
    if (r < 80) return $urandom_range(41, 600);
    if (r < 90) return TIMEOUT_RESET;
    return $urandom_range(1, 32'hFFFF_FFFF);
  endfunction

  task send_word(cmd_t cmd, logic [11:0] duty);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {4'b0, duty};
    do @(posedge clk); while (!in_tready);
    tracker.note_word(cmd, duty);
    words_sent++;
  endtask

  task drain();
    in_tvalid <= 1'b0;
    while (tracker.levels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(cfg_index_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_register(idx, val);
    @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        tracker.check_word(out_tdata);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_hold = pick_gap();
      end
    end
  end

  initial begin
    #1500000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int n;
    int write_pct;
    cmd_t cmd;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_word(CMD_WRITE, 12'd0);
    send_word(CMD_TICK, 12'hFFF);
    send_word(CMD_WRITE, 12'hFFF);
    send_word(CMD_TICK, 12'd0);
    send_word(CMD_WRITE, 12'(FULL_SCALE + 1));
    send_word(CMD_TICK, 12'hA5A);
    send_word(CMD_WRITE, 12'(FULL_SCALE));
    send_word(CMD_TICK, 12'h5A5);
    send_word(CMD_TICK, 12'd0);
    send_word(CMD_WRITE, 12'd1);
    send_word(CMD_TICK, 12'd0);
    drain();

    write_reg(CFG_PERIOD, 32'd4);
    write_reg(CFG_TIMEOUT, 32'd3);
    send_word(CMD_WRITE, 12'd500);
    repeat (5) send_word(CMD_TICK, 12'($urandom_range(0, 4095)));
    send_word(CMD_WRITE, 12'd250);
    send_word(CMD_TICK, 12'd0);
    send_word(CMD_WRITE, 12'd3);
    send_word(CMD_TICK, 12'd0);
    send_word(CMD_TICK, 12'd0);
    drain();

    while (words_sent < RANDOM_WORDS) begin
      n = $urandom_range(40, 150);
      if ($urandom_range(0, 99) < 70) begin
        write_reg(CFG_PERIOD, pick_period());
      end
      if ($urandom_range(0, 99) < 70) begin
        write_reg(CFG_TIMEOUT, pick_timeout());
      end
      idling_on = ($urandom_range(0, 3) != 0);
      write_pct = $urandom_range(3, 40);
      repeat (n) begin
        cmd = ($urandom_range(0, 99) < write_pct) ? CMD_WRITE : CMD_TICK;
        send_word(cmd, (cmd == CMD_WRITE) ? pick_duty() : 12'($urandom_range(0, 4095)));
      end
      drain();
    end

    write_reg(CFG_PERIOD, 32'd65535);
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    send_word(CMD_WRITE, 12'd999);
    repeat (20) send_word(CMD_TICK, 12'd0);
    drain();

    if (tracker.fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/pwmwd_pkg.sv
sv/pwmwd_ontime.sv
sv/pwm_generator_with_command_watchdog_core.sv
bench/tb_pwm_generator_with_command_watchdog_core.sv
